### src/bhq_pkg.sv
// shared types and constants of the binary max-heap priority queue
package bhq_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned CountW      = 7;
  localparam int unsigned CapacityDef = 64;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } bhq_op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } bhq_status_e;

  typedef struct packed {
    bhq_op_e                  op;
    logic signed [DataW-1:0]  value;
  } bhq_in_t;

  typedef struct packed {
    bhq_status_e              status;
    logic signed [DataW-1:0]  removed_value;
    logic signed [DataW-1:0]  top_value;
    logic [CountW-1:0]        count;
  } bhq_out_t;

  // one cell's contents as seen by its neighbours
  typedef struct packed {
    logic                     vld;
    logic signed [DataW-1:0]  key;
  } bhq_slot_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic signed [DataW-1:0]  key;
  } bhq_cmd_t;

endpackage

### src/binary_max_heap_queue.sv
// top level of the max priority queue built as a row of sorted cells
//
// usage
//   input channel: in_valid_i / in_stall_o with an op (insert or delete the
//   maximum) and a signed 32-bit value; a transfer happens on a rising edge
//   with valid high and stall low
//   output channel: out_valid_o / out_stall_i carrying status, removed
//   maximum, new top value and element count; one result per input transfer
//   storage: a row of Capacity cells kept in descending order, cell 0 is the
//   maximum; every cell takes its new content from itself, its left or its
//   right neighbour or the inserted key, all on the same edge
//   output register: the result is valid the cycle after the input transfer
//   throughput: one item per cycle unless a held result stalls the input
//   stall: the result sits in an output register; while it is stalled the
//   input is stalled too, once the result is taken a new transfer is taken
//   in the same cycle
//   reset: all cells empty, count zero, no result pending
//   refused ops: insert when full and delete when empty leave the row as it
//   is and report the matching status
module binary_max_heap_queue #(
  parameter int unsigned Capacity = bhq_pkg::CapacityDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  bhq_pkg::bhq_in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output bhq_pkg::bhq_out_t  out_data_o
);
  import bhq_pkg::*;

  localparam int unsigned CntW = $clog2(Capacity + 1);

  logic            accept;
  logic            full, empty;
  logic [CntW-1:0] count_q, count_d;
  bhq_cmd_t        cmd;
  bhq_out_t        res;
  bhq_out_t        out_q;
  logic            out_valid_q;

  // chain_w[i+1] is cell i; the two ends read as empty slots
  bhq_slot_t       chain_w [Capacity+2];
  // ge_w[i+1] is the keep flag of cell i; the head sees an always-true flag
  logic            ge_w    [Capacity+1];

  // only stall while a finished result is held back
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign full  = (count_q == CntW'(Capacity));
  assign empty = (count_q == '0);

  assign cmd.ins = accept && (in_data_i.op == OP_INSERT) && !full;
  assign cmd.del = accept && (in_data_i.op == OP_DELETE) && !empty;
  assign cmd.key = in_data_i.value;

  assign chain_w[0]          = '0;
  assign chain_w[Capacity+1] = '0;
  assign ge_w[0]             = 1'b1;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    bhq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .prev_i    (chain_w[i]),
      .prev_ge_i (ge_w[i]),
      .next_i    (chain_w[i+2]),
      .slot_o    (chain_w[i+1]),
      .ge_o      (ge_w[i+1])
    );
  end

  // result from the row before the edge: the head and its neighbour
  always_comb begin
    res.status        = ST_DONE;
    res.removed_value = '0;
    res.top_value     = chain_w[1].vld ? chain_w[1].key : '0;
    count_d           = count_q;
    case (in_data_i.op)
      OP_INSERT: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          res.top_value = ge_w[1] ? chain_w[1].key : in_data_i.value;
          count_d       = count_q + CntW'(1);
        end
      end
      OP_DELETE: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          res.removed_value = chain_w[1].key;
          res.top_value     = chain_w[2].vld ? chain_w[2].key : '0;
          count_d           = count_q - CntW'(1);
        end
      end
      default: begin
        res.status = ST_DONE;
      end
    endcase
    // count field is fixed at seven bits
    res.count = CountW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### src/bhq_cell.sv
// one cell of the sorted row: holds one key, shifts with its neighbours
module bhq_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bhq_pkg::bhq_cmd_t  cmd_i,
  input  bhq_pkg::bhq_slot_t prev_i,
  input  logic             prev_ge_i,
  input  bhq_pkg::bhq_slot_t next_i,
  output bhq_pkg::bhq_slot_t slot_o,
  output logic             ge_o
);
  import bhq_pkg::*;

  logic                    vld_q, vld_d;
  logic signed [DataW-1:0] key_q, key_d;

  // this cell keeps its key when it holds one that is at least the new one
  assign ge_o = vld_q && (key_q >= cmd_i.key);

  always_comb begin
    vld_d = vld_q;
    key_d = key_q;
    if (cmd_i.del) begin
      // everything moves one place towards the head
      vld_d = next_i.vld;
      key_d = next_i.key;
    end else if (cmd_i.ins && !ge_o) begin
      if (prev_ge_i) begin
        // insertion point
        vld_d = 1'b1;
        key_d = cmd_i.key;
      end else begin
        vld_d = prev_i.vld;
        key_d = prev_i.key;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign slot_o.vld = vld_q;
  assign slot_o.key = key_q;

endmodule

### src/bhq_checker.sv
// port-level assertions of the priority queue and their bind
module bhq_checker #(
  parameter int unsigned Capacity = bhq_pkg::CapacityDef
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input bhq_pkg::bhq_out_t  out_data_o
);
  import bhq_pkg::*;

  localparam logic [CountW-1:0] FullCount = CountW'(Capacity);

  // a held result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // every input transfer gives a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("input transfer without result");

  // a refused delete reports an empty queue and nothing removed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_EMPTY |->
      out_data_o.count == '0 && out_data_o.removed_value == '0 &&
      out_data_o.top_value == '0)
    else $error("bad result for refused delete");

  // a refused insert only happens at capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_FULL |-> out_data_o.count == FullCount)
    else $error("insert refused below capacity");

  // the input is only stalled behind a pending result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without pending result");

endmodule

bind binary_max_heap_queue bhq_checker #(.Capacity(Capacity)) u_bhq_checker (.*);

### test/binary_max_heap_queue_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the binary max-heap priority queue
module binary_max_heap_queue_test;
  import bhq_pkg::*;

  localparam int unsigned Capacity    = CapacityDef;
  localparam int unsigned RandomItems = 1320;
  // length of the forced receiver hold-off, in cycles
  localparam int unsigned HoldLen     = 400;
  // cycles without any transfer before the run is declared hung
  localparam int unsigned QuietLimit  = 4000;
  localparam logic signed [DataW-1:0] KeyMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] KeyMin = {1'b1, {(DataW-1){1'b0}}};

  // shadow heap plus the queue of results it has predicted
  class max_heap_board;
    logic signed [DataW-1:0] slots [Capacity];
    int unsigned             held;
    bhq_out_t                pending_results [$];
    int unsigned             mismatches;

    function new();
      held       = 0;
      mismatches = 0;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      logic signed [DataW-1:0] t;
      t        = slots[a];
      slots[a] = slots[b];
      slots[b] = t;
    endfunction

    // stops at an equal parent
    function void sift_up(int unsigned pos);
      int unsigned parent;
      while (pos != 0) begin
        parent = (pos - 1) / 2;
        if (slots[pos] > slots[parent]) begin
          swap_slots(pos, parent);
          pos = parent;
        end else begin
          break;
        end
      end
    endfunction

    // left child wins ties; a lone left child moves up when equal as well
    function void sift_down();
      int unsigned pos;
      int unsigned lc;
      int unsigned rc;
      bit          moving;
      pos    = 0;
      moving = 1'b1;
      while (moving) begin
        lc     = 2 * pos + 1;
        rc     = 2 * pos + 2;
        moving = 1'b0;
        if (rc < held) begin
          if (slots[lc] >= slots[rc] && slots[lc] > slots[pos]) begin
            swap_slots(lc, pos);
            pos    = lc;
            moving = 1'b1;
          end else if (slots[rc] >= slots[lc] && slots[rc] > slots[pos]) begin
            swap_slots(rc, pos);
            pos    = rc;
            moving = 1'b1;
          end
        end else if (lc < held) begin
          if (slots[lc] >= slots[pos]) begin
            swap_slots(lc, pos);
            pos    = lc;
            moving = 1'b1;
          end
        end
      end
    endfunction

    function void note_transfer(bhq_in_t item);
      bhq_out_t res;
      res        = '0;
      res.status = ST_DONE;
      if (item.op == OP_INSERT) begin
        if (held >= Capacity) begin
          res.status = ST_FULL;
        end else begin
          slots[held] = item.value;
          held++;
          sift_up(held - 1);
        end
      end else begin
        if (held == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.removed_value = slots[0];
          held--;
          slots[0] = slots[held];
          sift_down();
        end
      end
      if (held > 0) res.top_value = slots[0];
      res.count = CountW'(held);
      pending_results.insert(pending_results.size(), res);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 40) $display("%0t ns mismatch: %s", $time, what);
    endtask

    task check_result(bhq_out_t got);
      bhq_out_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with none expected, status %0d count %0d",
                                  got.status, got.count));
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.removed_value !== want.removed_value)
        report_mismatch($sformatf("removed_value %0d, expected %0d",
                                  got.removed_value, want.removed_value));
      if (got.top_value !== want.top_value)
        report_mismatch($sformatf("top_value %0d, expected %0d",
                                  got.top_value, want.top_value));
      if (got.count !== want.count)
        report_mismatch($sformatf("count %0d, expected %0d", got.count, want.count));
    endtask
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  bhq_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  bhq_out_t out_data_o;

  max_heap_board board = new();

  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 35;
  bit          hold_req      = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;

  always #2 clk_i = ~clk_i;

  binary_max_heap_queue #(
    .Capacity(Capacity)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // result side: check the transfer seen at this edge, then choose the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_data_o);
    if (hold_req) begin
      hold_left = HoldLen;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // hang detection: no transfer on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("binary_max_heap_queue_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one item, with random idle cycles first, and wait for its transfer
  task automatic send_item(input bhq_op_e op, input logic signed [DataW-1:0] value);
    bhq_in_t item;
    item.op    = op;
    item.value = value;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_transfer(item);
  endtask

  // mostly full-range keys, with extremes and a narrow band to force ties
  function automatic logic signed [DataW-1:0] pick_key();
    case ($urandom_range(9))
      0:       return KeyMax;
      1:       return KeyMin;
      2, 3:    return $urandom_range(8) - 4;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int          phase;
    int unsigned insert_pct;
    int unsigned run_len;
    int unsigned sent;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty delete, key extremes, ties, drain past empty
    send_item(OP_DELETE, KeyMax);
    send_item(OP_INSERT, '0);
    send_item(OP_INSERT, KeyMax);
    send_item(OP_INSERT, KeyMin);
    send_item(OP_INSERT, -1);
    send_item(OP_INSERT, KeyMax);
    repeat (3) send_item(OP_INSERT, 5);
    send_item(OP_INSERT, 6);
    repeat (11) send_item(OP_DELETE, -1);
    // three equal keys: after a delete a lone left child equals the root
    repeat (3) send_item(OP_INSERT, 3);
    send_item(OP_DELETE, '0);

    // random phases that swing between filling and draining
    sent  = 0;
    phase = 0;
    while (sent < RandomItems) begin
      case (phase % 6)
        0:       insert_pct = 85;
        1:       insert_pct = 15;
        2:       insert_pct = 50;
        3:       insert_pct = 95;
        4:       insert_pct = 10;
        default: insert_pct = 60;
      endcase
      // one stretch with no idling on either side
      send_idle_pct = (phase == 2) ? 0 : 35;
      recv_idle_pct = (phase == 2) ? 0 : 35;
      // long receiver hold-off while inserts keep coming
      if (phase == 3) hold_req = 1'b1;
      run_len = $urandom_range(150, 90);
      repeat (run_len) begin
        if (sent < RandomItems) begin
          send_item(($urandom_range(99) < insert_pct) ? OP_INSERT : OP_DELETE, pick_key());
          sent++;
        end
      end
      phase++;
    end
    in_valid_i <= 1'b0;

    while (board.pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("binary_max_heap_queue_test: done, clean");
    end else begin
      $display("binary_max_heap_queue_test: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
src/bhq_pkg.sv
src/bhq_cell.sv
src/binary_max_heap_queue.sv
src/bhq_checker.sv
test/binary_max_heap_queue_test.sv
